/* hw/rtl/pst_pkg.sv */
// Package for the per-source traffic statistics table.
// Holds the request/result structs, status codes, state enum and sizes.
// No dependencies.
package pst_pkg;

  localparam int TableEntriesDefault = 16;
  localparam int MaxResults = 16;
  localparam logic [7:0] STOP_MARK = 8'h77;

  localparam logic [1:0] ST_UPDATED = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_REPORT = 2'd3;

  localparam logic OP_PACKET = 1'b0;

  // packed record kept per slot in the entry memory
  typedef struct packed {
    logic        finished;
    logic [31:0] addr;
    logic [47:0] bytes;
    logic [31:0] packets;
    logic [31:0] seconds;
    logic [31:0] byte_rate;
    logic [31:0] packet_rate;
    logic [31:0] lost;
  } entry_t;

  localparam int EntryBits = $bits(entry_t);

  typedef struct packed {
    logic        opcode;
    logic [31:0] src_address;
    logic [11:0] length;
    logic [7:0]  marker_byte;
    logic [30:0] sender_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] entry_address;
    logic [47:0] byte_total;
    logic [31:0] seconds;
    logic [31:0] byte_rate_kib;
    logic [31:0] packet_total;
    logic signed [31:0] lost_count;
    logic [31:0] packet_rate;
    logic        finished;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK_RD,
    S_LOOK_CMP,
    S_PKT_DONE,
    S_TICK_RD,
    S_TICK_WAIT,
    S_DIV_BYTES,
    S_DIV_PKTS,
    S_TICK_WR,
    S_REP_RD,
    S_REP_EMIT
  } state_t;

endpackage

/* hw/rtl/pst_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module pst_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/per_source_traffic_stats_table_core.sv */
// Per-source traffic statistics table: top level.
// Depends on pst_pkg and pst_ram.
//
// Use: present a request on in_item with start high while busy is low. A
// packet request (opcode 0) looks its source up in the table, walking slots
// in turn through the entry memory (registered read: each slot is read, then
// compared), and gives one result: updated, inserted or table full. The walk
// covers every slot for an insert or a drop, and the next request can be
// taken in the cycle after the result is strobed. A tick request (opcode 1)
// walks every slot: each unfinished valid entry gains one second and has its
// rates recomputed by a shared radix-2 divider (48 steps for bytes, 32 for
// packets, one bit a cycle). Then slots are scanned highest first (memory
// read then strobe), one report per valid entry up to MaxResults; the final
// one carries last. Results appear on out_item for exactly one cycle marked
// by out_valid; the receiver cannot stall. busy stays high from acceptance
// until the last result has been strobed. Synchronous reset clears all valid
// bits; memory contents are left undefined.
module per_source_traffic_stats_table_core #(
  parameter int TABLE_ENTRIES = pst_pkg::TableEntriesDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pst_pkg::in_item_t   in_item,
  output logic                out_valid,
  output pst_pkg::out_item_t  out_item
);
  import pst_pkg::*;

  localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CntW = $clog2(MaxResults + 1);
  localparam logic [IdxW:0] LastSlot = (IdxW + 1)'(TABLE_ENTRIES - 1);

  state_t state_r, state_nxt;
  in_item_t req_r;
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [IdxW:0] slot_r, slot_nxt;
  logic [CntW-1:0] rep_cnt_r;
  entry_t ent_r;
  logic [5:0] step_r;
  logic [47:0] quo_r, rem_r;
  logic [31:0] sec_r;
  logic found_r;

  // memory port
  logic          mem_we;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, mem_rdata;

  pst_ram #(.Width(EntryBits), .Depth(TABLE_ENTRIES)) u_ram (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  logic [IdxW-1:0] slot_idx;
  assign slot_idx = slot_r[IdxW-1:0];
  assign mem_raddr = slot_idx;

  // lowest free slot
  logic free_any;
  logic [IdxW-1:0] free_idx;
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  // divider step: dividend shifted in from quo_r, divisor sec_r
  logic [48:0] trial;
  assign trial = {rem_r, quo_r[47]} - {17'd0, sec_r};
  logic [47:0] quo_step;
  assign quo_step = {quo_r[46:0], ~trial[48]};
  logic [47:0] kib_q;
  assign kib_q = quo_step >> 10;

  logic [48:0] bytes_sum;
  assign bytes_sum = {1'b0, ent_r.bytes} + 49'(req_r.length);
  logic is_match;
  assign is_match = valid_r[slot_idx] && (mem_rdata.addr == req_r.src_address);

  // report scan: hit on the current slot, and whether any valid slot lies below slot_r
  logic rep_hit;
  assign rep_hit = valid_r[slot_idx];
  logic rep_more;
  always_comb begin
    rep_more = 1'b0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (valid_r[i] && (IdxW + 1)'(i) < slot_r) rep_more = 1'b1;
    end
  end

  logic last_rep;
  assign last_rep = !rep_more || (rep_cnt_r + 1'b1 == CntW'(MaxResults));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = (in_item.opcode == OP_PACKET) ? S_LOOK_RD : S_TICK_RD;
      end
      S_LOOK_RD:   state_nxt = S_LOOK_CMP;
      S_LOOK_CMP: begin
        if (is_match || slot_r == LastSlot) state_nxt = S_PKT_DONE;
        else state_nxt = S_LOOK_RD;
      end
      S_PKT_DONE:  state_nxt = S_IDLE;
      S_TICK_RD:   state_nxt = S_TICK_WAIT;
      S_TICK_WAIT: begin
        if (valid_r[slot_idx] && !mem_rdata.finished) state_nxt = S_DIV_BYTES;
        else if (slot_r == LastSlot) state_nxt = S_REP_RD;
        else state_nxt = S_TICK_RD;
      end
      S_DIV_BYTES: if (step_r == 6'd47) state_nxt = S_DIV_PKTS;
      S_DIV_PKTS:  if (step_r == 6'd31) state_nxt = S_TICK_WR;
      S_TICK_WR:   state_nxt = (slot_r == LastSlot) ? S_REP_RD : S_TICK_RD;
      S_REP_RD:    state_nxt = S_REP_EMIT;
      S_REP_EMIT: begin
        if (slot_r == '0 || rep_cnt_r == CntW'(MaxResults) || (rep_hit && last_rep)) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_REP_RD;
        end
      end
      default:     state_nxt = S_IDLE;
    endcase
  end

  // slot counter
  always_comb begin
    slot_nxt = slot_r;
    unique case (state_r)
      S_IDLE:      slot_nxt = '0;
      S_LOOK_CMP:  if (!is_match && slot_r != LastSlot) slot_nxt = slot_r + 1'b1;
      S_TICK_WAIT: begin
        if (!(valid_r[slot_idx] && !mem_rdata.finished)) begin
          slot_nxt = (slot_r == LastSlot) ? LastSlot : slot_r + 1'b1;
        end
      end
      S_TICK_WR:   slot_nxt = (slot_r == LastSlot) ? LastSlot : slot_r + 1'b1;
      S_REP_EMIT:  if (slot_r != '0) slot_nxt = slot_r - 1'b1;
      default:     slot_nxt = slot_r;
    endcase
  end

  // memory write and outputs
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = slot_idx;
    mem_wdata = ent_r;
    out_valid = 1'b0;
    out_item = '0;
    busy = (state_r != S_IDLE);
    unique case (state_r)
      S_PKT_DONE: begin
        out_valid = 1'b1;
        out_item.last = 1'b1;
        if (found_r) begin
          mem_we = 1'b1;
          if (req_r.marker_byte == STOP_MARK) begin
            mem_wdata.finished = 1'b1;
            mem_wdata.lost = {1'b0, req_r.sender_count} - ent_r.packets;
          end else begin
            mem_wdata.finished = 1'b0;
            mem_wdata.bytes = bytes_sum[48] ? '1 : bytes_sum[47:0];
            if (ent_r.packets != '1) mem_wdata.packets = ent_r.packets + 1'b1;
          end
          out_item.status = ST_UPDATED;
        end else if (free_any) begin
          mem_we = 1'b1;
          mem_waddr = free_idx;
          mem_wdata = '0;
          mem_wdata.addr = req_r.src_address;
          mem_wdata.bytes = 48'(req_r.length);
          out_item.status = ST_INSERTED;
        end else begin
          out_item.status = ST_FULL;
          out_item.entry_address = req_r.src_address;
        end
        if (found_r || free_any) begin
          out_item.entry_address = mem_wdata.addr;
          out_item.byte_total = mem_wdata.bytes;
          out_item.seconds = mem_wdata.seconds;
          out_item.byte_rate_kib = mem_wdata.byte_rate;
          out_item.packet_total = mem_wdata.packets;
          out_item.lost_count = mem_wdata.lost;
          out_item.packet_rate = mem_wdata.packet_rate;
          out_item.finished = mem_wdata.finished;
        end
      end
      S_TICK_WR: begin
        mem_we = 1'b1;
        mem_wdata.seconds = sec_r;
        mem_wdata.packet_rate = quo_r[31:0];
      end
      S_REP_EMIT: begin
        if (rep_hit) begin
          out_valid = 1'b1;
          out_item.status = ST_REPORT;
          out_item.entry_address = mem_rdata.addr;
          out_item.byte_total = mem_rdata.bytes;
          out_item.seconds = mem_rdata.seconds;
          out_item.byte_rate_kib = mem_rdata.byte_rate;
          out_item.packet_total = mem_rdata.packets;
          out_item.lost_count = mem_rdata.lost;
          out_item.packet_rate = mem_rdata.packet_rate;
          out_item.finished = mem_rdata.finished;
          out_item.last = last_rep;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      slot_r <= '0;
      rep_cnt_r <= '0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      slot_r <= slot_nxt;
      if (state_r == S_IDLE) begin
        found_r <= 1'b0;
        rep_cnt_r <= '0;
      end
      if (state_r == S_LOOK_CMP && is_match) found_r <= 1'b1;
      if (state_r == S_PKT_DONE && !found_r && free_any) valid_r[free_idx] <= 1'b1;
      if (state_r == S_REP_EMIT && rep_hit) rep_cnt_r <= rep_cnt_r + 1'b1;
    end
  end

  // payload and divider registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) req_r <= in_item;
    if (state_r == S_LOOK_CMP && is_match) ent_r <= mem_rdata;
    if (state_r == S_TICK_WAIT) begin
      ent_r <= mem_rdata;
      sec_r <= (mem_rdata.seconds == '1) ? '1 : mem_rdata.seconds + 1'b1;
      quo_r <= mem_rdata.bytes;
      rem_r <= '0;
      step_r <= '0;
    end else if (state_r == S_DIV_BYTES && step_r == 6'd47) begin
      // quotient/1024, saturate to 32 bits; restart on packets
      ent_r.byte_rate <= (kib_q > 48'hFFFF_FFFF) ? '1 : kib_q[31:0];
      quo_r <= {ent_r.packets, 16'd0};
      rem_r <= '0;
      step_r <= '0;
    end else if (state_r == S_DIV_BYTES || state_r == S_DIV_PKTS) begin
      rem_r <= trial[48] ? {rem_r[46:0], quo_r[47]} : trial[47:0];
      quo_r <= quo_step;
      step_r <= step_r + 1'b1;
    end
  end

endmodule

/* verif/pst_checker.sv */
// Checker for the per-source traffic statistics table.
// Watches accepted requests and strobed results, predicts and compares.
// Depends on pst_pkg.
module pst_checker #(
  parameter int TABLE_ENTRIES = pst_pkg::TableEntriesDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  pst_pkg::in_item_t   in_item,
  input  logic                out_valid,
  input  pst_pkg::out_item_t  out_item,
  output int                  fail_count,
  output int                  pending,
  output int                  reports_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import pst_pkg::*;

  localparam logic [47:0] BYTES_MAX = 48'hFFFF_FFFF_FFFF;

  logic        slot_valid [TABLE_ENTRIES];
  logic        slot_fin   [TABLE_ENTRIES];
  logic [31:0] slot_addr  [TABLE_ENTRIES];
  logic [47:0] slot_bytes [TABLE_ENTRIES];
  logic [31:0] slot_pkts  [TABLE_ENTRIES];
  logic [31:0] slot_secs  [TABLE_ENTRIES];
  logic [31:0] slot_brate [TABLE_ENTRIES];
  logic [31:0] slot_prate [TABLE_ENTRIES];
  logic [31:0] slot_lost  [TABLE_ENTRIES];

  out_item_t expected_results[$];

  assign pending = expected_results.size();

  function automatic out_item_t slot_result(int s, logic [1:0] st);
    out_item_t r;
    r.status        = st;
    r.entry_address = slot_addr[s];
    r.byte_total    = slot_bytes[s];
    r.seconds       = slot_secs[s];
    r.byte_rate_kib = slot_brate[s];
    r.packet_total  = slot_pkts[s];
    r.lost_count    = slot_lost[s];
    r.packet_rate   = slot_prate[s];
    r.finished      = slot_fin[s];
    r.last          = 1'b0;
    return r;
  endfunction

  // apply one packet request to the table
  task automatic update_table_packet(in_item_t it);
    out_item_t r;
    logic [48:0] sum;
    int free_slot;
    free_slot = -1;
    for (int s = 0; s < TABLE_ENTRIES; s++) begin
      if (slot_valid[s] && slot_addr[s] == it.src_address) begin
        if (it.marker_byte == STOP_MARK) begin
          slot_fin[s]  = 1'b1;
          slot_lost[s] = {1'b0, it.sender_count} - slot_pkts[s];
        end else begin
          slot_fin[s] = 1'b0;
          sum = slot_bytes[s] + it.length;
          slot_bytes[s] = sum[48] ? BYTES_MAX : sum[47:0];
          if (slot_pkts[s] != 32'hFFFF_FFFF) slot_pkts[s]++;
        end
        r = slot_result(s, ST_UPDATED);
        r.last = 1'b1;
        expected_results.push_back(r);
        return;
      end
    end
    for (int s = TABLE_ENTRIES - 1; s >= 0; s--) if (!slot_valid[s]) free_slot = s;
    if (free_slot >= 0) begin
      slot_valid[free_slot] = 1'b1;
      slot_fin[free_slot]   = 1'b0;
      slot_addr[free_slot]  = it.src_address;
      slot_bytes[free_slot] = {36'd0, it.length};
      slot_pkts[free_slot]  = '0;
      slot_secs[free_slot]  = '0;
      slot_brate[free_slot] = '0;
      slot_prate[free_slot] = '0;
      slot_lost[free_slot]  = '0;
      r = slot_result(free_slot, ST_INSERTED);
    end else begin
      r = '0;
      r.status = ST_FULL;
      r.entry_address = it.src_address;
    end
    r.last = 1'b1;
    expected_results.push_back(r);
  endtask

  // advance time, recompute rates, queue reports newest first
  task automatic advance_tick();
    logic [63:0] secs, kib;
    int n;
    n = 0;
    for (int s = 0; s < TABLE_ENTRIES; s++) begin
      if (slot_valid[s] && !slot_fin[s]) begin
        secs = slot_secs[s] + 64'd1;
        if (secs > 64'hFFFF_FFFF) secs = 64'hFFFF_FFFF;
        slot_secs[s] = secs[31:0];
        kib = {16'd0, slot_bytes[s]} / secs / 64'd1024;
        slot_brate[s] = (kib > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : kib[31:0];
        slot_prate[s] = 32'({32'd0, slot_pkts[s]} / secs);
      end
    end
    for (int s = TABLE_ENTRIES - 1; s >= 0 && n < MaxResults; s--) begin
      if (slot_valid[s]) begin
        expected_results.push_back(slot_result(s, ST_REPORT));
        n++;
      end
    end
    if (n > 0) expected_results[expected_results.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      for (int s = 0; s < TABLE_ENTRIES; s++) begin
        slot_valid[s] = 1'b0;
        slot_fin[s]   = 1'b0;
      end
      expected_results.delete();
      fail_count <= 0;
      reports_seen <= 0;
    end else begin
      // compare the strobed result first: it belongs to an earlier request
      if (out_valid) begin
        if (out_item.status == ST_REPORT) reports_seen <= reports_seen + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_item);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_results.pop_front();
          if (out_item !== e) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, out_item);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        if (in_item.opcode == OP_PACKET) update_table_packet(in_item);
        else advance_tick();
      end
    end
  end
endmodule

/* verif/per_source_traffic_stats_table_core_tb.sv */
// Testbench top for the per-source traffic statistics table.
// Drives packet and tick requests; verdict from pst_checker.
// Depends on pst_pkg, pst_checker and the block.
module per_source_traffic_stats_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pst_pkg::*;

  localparam int LIMIT_CYCLES = 5_000_000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;
  int        fail_count, pending, reports_seen;
  int        cycle_count;
  int        requests_sent;
  logic      no_gaps;
  logic [31:0] addr_pool [24];

  per_source_traffic_stats_table_core #(.TABLE_ENTRIES(16)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  pst_checker #(.TABLE_ENTRIES(16)) chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .fail_count(fail_count),
    .pending(pending), .reports_seen(reports_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop on timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("per_source_traffic_stats_table_core verification failed");
      $finish;
    end
  end

  // present one request and hold it until the block is no longer busy
  task automatic send_request(in_item_t it);
    while (!no_gaps && $urandom_range(99) < 31) @(posedge clk);
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    requests_sent++;
    @(posedge clk);
  endtask

  function automatic in_item_t packet_req(logic [31:0] a, logic [11:0] len,
                                          logic [7:0] mk, logic [30:0] cnt);
    in_item_t it;
    it.opcode = OP_PACKET;
    it.src_address = a;
    it.length = len;
    it.marker_byte = mk;
    it.sender_count = cnt;
    return it;
  endfunction

  function automatic in_item_t tick_req();
    in_item_t it;
    it.src_address = $urandom;
    it.length = 12'($urandom);
    it.marker_byte = 8'($urandom);
    it.sender_count = 31'($urandom);
    it.opcode = ~OP_PACKET;
    return it;
  endfunction

  function automatic logic [7:0] rand_marker();
    logic [7:0] m;
    m = $urandom_range(255);
    if ($urandom_range(9) < 2) m = STOP_MARK;
    return m;
  endfunction

  initial begin
    in_item_t it;
    cycle_count = 0;
    requests_sent = 0;
    no_gaps = 1'b0;
    start = 1'b0;
    in_item = '0;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty tick, inserts at field extremes, stop and resume, full table
    send_request(tick_req());
    send_request(packet_req(32'h0, 12'd1, 8'h00, 31'd0));
    send_request(packet_req(32'hFFFF_FFFF, 12'hFFF, 8'hFF, 31'h7FFF_FFFF));
    send_request(packet_req(32'hFFFF_FFFF, 12'd0, 8'h55, 31'd0));
    send_request(packet_req(32'h0, 12'd2048, 8'h00, 31'd5));
    send_request(tick_req());
    send_request(packet_req(32'h0, 12'd7, STOP_MARK, 31'h7FFF_FFFF));
    send_request(packet_req(32'hFFFF_FFFF, 12'd3, STOP_MARK, 31'd0));
    send_request(tick_req());
    send_request(packet_req(32'h0, 12'd9, 8'hAA, 31'h2AAA_AAAA));
    for (int i = 0; i < 15; i++)
      send_request(packet_req(32'hC0A8_0000 + i, 12'($urandom_range(1, 2048)),
                              8'($urandom), 31'($urandom)));
    send_request(tick_req());

    // reset table contents is not possible: spread random addresses from a pool
    for (int i = 0; i < 24; i++) addr_pool[i] = $urandom;
    for (int i = 0; i < 370; i++) begin
      no_gaps = (i >= 150 && i < 210);
      if ($urandom_range(9) == 0) it = tick_req();
      else if ($urandom_range(9) == 0)
        it = packet_req($urandom, 12'($urandom), 8'($urandom), 31'($urandom));
      else
        it = packet_req(addr_pool[$urandom_range(23)], 12'($urandom_range(1, 2048)),
                        rand_marker(), 31'($urandom));
      send_request(it);
    end
    no_gaps = 1'b0;

    // drain outstanding results then settle
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("ran %0d requests (packets and ticks), %0d entry reports checked",
             requests_sent, reports_seen);
    if (fail_count == 0) $display("per_source_traffic_stats_table_core verification clean");
    else $display("per_source_traffic_stats_table_core verification failed");
    $finish;
  end
endmodule
